// ===== hdl/lesm_pkg.sv =====
package lesm_pkg;

	localparam int POINT_COUNT_DEF = 21;

	localparam int COORD_W   = 16;
	localparam int TICK_W    = 32;
	localparam int HORIZON_W = 10;
	localparam int CFG_ADDR_W = 2;
	localparam int CFG_DATA_W = 16;

	// factor numerator is horizon_ms in Q.14
	localparam int FRAC_Q14  = 14;
	localparam int NUM_W     = HORIZON_W + FRAC_Q14;
	localparam int DIV_STEPS = NUM_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	localparam int MAG_W  = COORD_W + 1;
	localparam int PROD_W = MAG_W + COORD_W;

	localparam int IN_DATA_W  = TICK_W + 3 * COORD_W;
	localparam int OUT_DATA_W = 3 * COORD_W;

	localparam logic [COORD_W-1:0] ONE_Q15 = 16'd32768;
	localparam logic [COORD_W-1:0] HALF_Q15 = 16'd16384;

	localparam logic [HORIZON_W-1:0] HORIZON_RST = 10'd45;
	localparam logic [COORD_W-1:0]   MAX_STEP_RST = 16'd2621;
	localparam logic [COORD_W-1:0]   BLEND_RST = 16'd24576;
	localparam logic [COORD_W-1:0]   FACTOR_LIM_RST = 16'd24576;

	localparam logic [CFG_ADDR_W-1:0] REG_HORIZON    = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_MAX_STEP   = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_BLEND      = 2'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_FACTOR_LIM = 2'd3;

	localparam logic OP_POINT = 1'b0;
	localparam logic OP_CLEAR = 1'b1;

	typedef struct packed {
		logic load;      // capture point, read history slot
		logic first;     // first point of a frame: record tick
		logic div_start;
		logic div_step;
		logic fact;      // latch clamped quotient as frame factor
		logic mul1;
		logic pred;
		logic mul2;
		logic fin;       // write history, load output word
		logic pass;      // no history yet: answer the point unchanged
	} cmd_t;

	typedef struct packed {
		logic out_hold;  // output word still waiting
	} sts_t;

	typedef struct packed {
		logic             neg;
		logic [MAG_W-1:0] mag;
	} step_t;

	function automatic logic [COORD_W-1:0] sat_coord(input logic [COORD_W-1:0] v);
		sat_coord = (v > ONE_Q15) ? ONE_Q15 : v;
	endfunction

	// clamped per-frame motion as sign and magnitude
	function automatic step_t axis_step(input logic [COORD_W-1:0] cur,
			input logic [COORD_W-1:0] prev, input logic [COORD_W-1:0] lim);
		logic signed [COORD_W+1:0] diff;
		logic signed [COORD_W+1:0] lim_s;
		logic signed [COORD_W+1:0] abs_v;
		step_t r;
		diff = $signed({2'b00, cur}) - $signed({2'b00, prev});
		lim_s = $signed({2'b00, lim});
		if (diff > lim_s) begin
			diff = lim_s;
		end else if (diff < -lim_s) begin
			diff = -lim_s;
		end
		r.neg = diff[COORD_W+1];
		abs_v = r.neg ? -diff : diff;
		r.mag = abs_v[MAG_W-1:0];
		axis_step = r;
	endfunction

	// round motion half away from zero, add, clamp to unit range
	function automatic logic [COORD_W-1:0] axis_pred(input logic [COORD_W-1:0] cur,
			input logic [PROD_W-1:0] prod, input logic neg);
		logic [PROD_W:0] rnd;
		logic [PROD_W-FRAC_Q14:0] motion;
		logic signed [PROD_W-FRAC_Q14+2:0] p;
		logic [COORD_W-1:0] r;
		rnd = {1'b0, prod} + (PROD_W+1)'(1 << (FRAC_Q14 - 1));
		motion = rnd[PROD_W:FRAC_Q14];
		if (neg) begin
			p = $signed((PROD_W-FRAC_Q14+3)'(cur)) - $signed({2'b00, motion});
		end else begin
			p = $signed((PROD_W-FRAC_Q14+3)'(cur)) + $signed({2'b00, motion});
		end
		if (p < 0) begin
			r = '0;
		end else if (p > $signed((PROD_W-FRAC_Q14+3)'(ONE_Q15))) begin
			r = ONE_Q15;
		end else begin
			r = p[COORD_W-1:0];
		end
		axis_pred = r;
	endfunction

endpackage

// ===== hdl/lesm_div.sv =====
module lesm_div (
	input  logic                               clk,
	input  logic                               start,
	input  logic                               step,
	input  logic [lesm_pkg::NUM_W-1:0]         num,
	input  logic [lesm_pkg::TICK_W-1:0]        den,
	output logic [lesm_pkg::NUM_W-1:0]         quot
);

	logic [lesm_pkg::TICK_W-1:0] rem_q;
	logic [lesm_pkg::TICK_W-1:0] den_q;
	logic [lesm_pkg::NUM_W-1:0]  quot_q;
	logic [lesm_pkg::TICK_W:0]   trial;
	logic                        fits;

	// restoring division, one quotient bit per cycle while step is high
	assign trial = {rem_q, quot_q[lesm_pkg::NUM_W-1]};
	assign fits = trial >= {1'b0, den_q};

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= den;
			quot_q <= num;
		end else if (step) begin
			rem_q <= fits ? lesm_pkg::TICK_W'(trial - {1'b0, den_q})
			              : trial[lesm_pkg::TICK_W-1:0];
			quot_q <= {quot_q[lesm_pkg::NUM_W-2:0], fits};
		end
	end

	assign quot = quot_q;

endmodule

// ===== hdl/lesm_ctrl.sv =====
module lesm_ctrl #(
	parameter int POINT_COUNT = lesm_pkg::POINT_COUNT_DEF,
	parameter int IDX_W = 5
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic              s_tuser,
	input  logic              s_tlast,
	input  lesm_pkg::sts_t    sts,
	output lesm_pkg::cmd_t    cmd,
	output logic [IDX_W-1:0]  idx
);

	typedef enum logic [2:0] {
		IDLE,
		DIV,
		FACT,
		MUL1,
		PRED,
		MUL2,
		FIN
	} state_t;

	state_t                        state_q;
	logic                          hist_q;
	logic [IDX_W-1:0]              idx_q;
	logic                          end_q;
	logic [lesm_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                          accept;
	logic                          is_point;
	logic                          do_fin;

	assign s_tready = (state_q == IDLE);
	assign accept = s_tvalid && s_tready;
	assign is_point = accept && (s_tuser == lesm_pkg::OP_POINT);
	assign do_fin = (state_q == FIN) && !sts.out_hold;

	always_comb begin
		cmd = '0;
		cmd.load = is_point;
		cmd.first = is_point && (idx_q == '0);
		cmd.div_start = is_point && (idx_q == '0) && hist_q;
		cmd.div_step = (state_q == DIV);
		cmd.fact = (state_q == FACT);
		cmd.mul1 = (state_q == MUL1);
		cmd.pred = (state_q == PRED);
		cmd.mul2 = (state_q == MUL2);
		cmd.fin = do_fin;
		cmd.pass = !hist_q;
	end

	assign idx = idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			hist_q <= 1'b0;
			idx_q <= '0;
			end_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			case (state_q)
				IDLE: begin
					if (accept) begin
						if (s_tuser == lesm_pkg::OP_CLEAR) begin
							hist_q <= 1'b0;
							idx_q <= '0;
						end else begin
							end_q <= s_tlast;
							cnt_q <= '0;
							state_q <= cmd.div_start ? DIV : MUL1;
						end
					end
				end
				DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == lesm_pkg::DIV_CNT_W'(lesm_pkg::DIV_STEPS - 1)) begin
						state_q <= FACT;
					end
				end
				FACT: state_q <= MUL1;
				MUL1: state_q <= PRED;
				PRED: state_q <= MUL2;
				MUL2: state_q <= FIN;
				FIN: begin
					if (do_fin) begin
						if (end_q || idx_q == IDX_W'(POINT_COUNT - 1)) begin
							idx_q <= '0;
							hist_q <= 1'b1;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
						state_q <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

endmodule

// ===== hdl/lesm_dp.sv =====
module lesm_dp #(
	parameter int POINT_COUNT = lesm_pkg::POINT_COUNT_DEF,
	parameter int IDX_W = 5
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [lesm_pkg::CFG_ADDR_W-1:0]     cfg_addr,
	input  logic [lesm_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	input  logic [lesm_pkg::IN_DATA_W-1:0]      s_tdata,
	input  logic                                s_tlast,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [lesm_pkg::OUT_DATA_W-1:0]     m_tdata,
	output logic                                m_tlast,
	input  lesm_pkg::cmd_t                      cmd,
	input  logic [IDX_W-1:0]                    idx,
	output lesm_pkg::sts_t                      sts
);

	localparam int CW = lesm_pkg::COORD_W;

	logic [lesm_pkg::HORIZON_W-1:0] horizon_q;
	logic [CW-1:0] max_step_q;
	logic [CW-1:0] blend_q;
	logic [CW-1:0] factor_lim_q;

	logic [lesm_pkg::TICK_W-1:0] last_tick_q;
	logic [CW-1:0] factor_q;

	logic [2*CW-1:0] prev_mem [POINT_COUNT];
	logic [2*CW-1:0] smooth_mem [POINT_COUNT];

	logic [CW-1:0] x_q, y_q, z_q;
	logic          end_q;
	logic [2*CW-1:0] prev_rd_q;
	logic [2*CW-1:0] smooth_rd_q;

	logic [lesm_pkg::PROD_W-1:0] prod_x_s1, prod_y_s1;
	logic neg_x_s1, neg_y_s1;
	logic [CW-1:0] p_x_s2, p_y_s2;
	logic [2*CW-1:0] a_x_s3, a_y_s3, b_x_s3, b_y_s3;

	logic out_valid_q;
	logic [lesm_pkg::OUT_DATA_W-1:0] out_data_q;
	logic out_last_q;

	logic [lesm_pkg::TICK_W-1:0] in_tick;
	logic [lesm_pkg::TICK_W-1:0] dt;
	logic [lesm_pkg::TICK_W-1:0] den;
	logic [lesm_pkg::NUM_W-1:0]  quot;
	lesm_pkg::step_t st_x, st_y;
	logic [CW-1:0] w, wc;
	logic [2*CW-1:0] sum_x, sum_y;
	logic [CW-1:0] ox, oy;

	assign in_tick = s_tdata[lesm_pkg::TICK_W-1:0];
	assign dt = in_tick - last_tick_q;
	assign den = (dt == '0) ? lesm_pkg::TICK_W'(1) : dt;

	lesm_div u_div (
		.clk   (clk),
		.start (cmd.div_start),
		.step  (cmd.div_step),
		.num   ({horizon_q, lesm_pkg::FRAC_Q14'(0)}),
		.den   (den),
		.quot  (quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			horizon_q <= lesm_pkg::HORIZON_RST;
			max_step_q <= lesm_pkg::MAX_STEP_RST;
			blend_q <= lesm_pkg::BLEND_RST;
			factor_lim_q <= lesm_pkg::FACTOR_LIM_RST;
			last_tick_q <= '0;
			factor_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					lesm_pkg::REG_HORIZON:    horizon_q <= cfg_wdata[lesm_pkg::HORIZON_W-1:0];
					lesm_pkg::REG_MAX_STEP:   max_step_q <= cfg_wdata;
					lesm_pkg::REG_BLEND:      blend_q <= cfg_wdata;
					lesm_pkg::REG_FACTOR_LIM: factor_lim_q <= cfg_wdata;
					default: ;
				endcase
			end
			if (cmd.first) begin
				last_tick_q <= in_tick;
			end
			if (cmd.fact) begin
				factor_q <= (quot > lesm_pkg::NUM_W'(factor_lim_q)) ? factor_lim_q
				                                                   : quot[CW-1:0];
			end
			if (cmd.fin) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign st_x = lesm_pkg::axis_step(x_q, prev_rd_q[CW-1:0], max_step_q);
	assign st_y = lesm_pkg::axis_step(y_q, prev_rd_q[2*CW-1:CW], max_step_q);
	assign w = (blend_q > lesm_pkg::ONE_Q15) ? lesm_pkg::ONE_Q15 : blend_q;
	assign wc = lesm_pkg::ONE_Q15 - w;
	assign sum_x = a_x_s3 + b_x_s3 + (2*CW)'(lesm_pkg::HALF_Q15);
	assign sum_y = a_y_s3 + b_y_s3 + (2*CW)'(lesm_pkg::HALF_Q15);
	assign ox = cmd.pass ? x_q : sum_x[2*CW-2:CW-1];
	assign oy = cmd.pass ? y_q : sum_y[2*CW-2:CW-1];

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q <= lesm_pkg::sat_coord(s_tdata[lesm_pkg::TICK_W +: CW]);
			y_q <= lesm_pkg::sat_coord(s_tdata[lesm_pkg::TICK_W+CW +: CW]);
			z_q <= s_tdata[lesm_pkg::TICK_W+2*CW +: CW];
			end_q <= s_tlast;
			prev_rd_q <= prev_mem[idx];
			smooth_rd_q <= smooth_mem[idx];
		end
		if (cmd.mul1) begin
			prod_x_s1 <= st_x.mag * factor_q;
			prod_y_s1 <= st_y.mag * factor_q;
			neg_x_s1 <= st_x.neg;
			neg_y_s1 <= st_y.neg;
		end
		if (cmd.pred) begin
			p_x_s2 <= lesm_pkg::axis_pred(x_q, prod_x_s1, neg_x_s1);
			p_y_s2 <= lesm_pkg::axis_pred(y_q, prod_y_s1, neg_y_s1);
		end
		if (cmd.mul2) begin
			a_x_s3 <= w * p_x_s2;
			a_y_s3 <= w * p_y_s2;
			b_x_s3 <= wc * smooth_rd_q[CW-1:0];
			b_y_s3 <= wc * smooth_rd_q[2*CW-1:CW];
		end
		if (cmd.fin) begin
			prev_mem[idx] <= {y_q, x_q};
			smooth_mem[idx] <= {oy, ox};
			out_data_q <= {z_q, oy, ox};
			out_last_q <= end_q;
		end
	end

	assign sts.out_hold = out_valid_q && !m_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata = out_data_q;
	assign m_tlast = out_last_q;

endmodule

// ===== hdl/landmark_extrapolate_smooth_core.sv =====
// output: m_tvalid rises after an accepted point word passes MUL1, PRED, MUL2 and FIN; the first
// point of a frame with history first runs the bit-serial factor divider (24 steps) and the clamp
// input: s_tready is high only in IDLE, so a new word waits until the previous point is finished,
// and FIN waits while the output word is not taken; a clear word gives no result
// reset: arst_n clears control state, history flag, index, frame tick and factor, and loads
// the register defaults; point history memories are not cleared
module landmark_extrapolate_smooth_core #(
	parameter int POINT_COUNT = lesm_pkg::POINT_COUNT_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [lesm_pkg::CFG_ADDR_W-1:0]     cfg_addr,
	input  logic [lesm_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [lesm_pkg::IN_DATA_W-1:0]      s_tdata,  // tick_ms, point_x, point_y, point_z
	input  logic                                s_tuser,  // operation
	input  logic                                s_tlast,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [lesm_pkg::OUT_DATA_W-1:0]     m_tdata,  // pred_x, pred_y, pred_z
	output logic                                m_tlast
);

	localparam int IDX_W = (POINT_COUNT > 1) ? $clog2(POINT_COUNT) : 1;

	lesm_pkg::cmd_t   cmd;
	lesm_pkg::sts_t   sts;
	logic [IDX_W-1:0] idx;

	lesm_ctrl #(
		.POINT_COUNT (POINT_COUNT),
		.IDX_W       (IDX_W)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.sts      (sts),
		.cmd      (cmd),
		.idx      (idx)
	);

	lesm_dp #(
		.POINT_COUNT (POINT_COUNT),
		.IDX_W       (IDX_W)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cmd       (cmd),
		.idx       (idx),
		.sts       (sts)
	);

endmodule

// ===== test/tb.sv =====
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NPTS        = lesm_pkg::POINT_COUNT_DEF;
	localparam int CW          = lesm_pkg::COORD_W;
	localparam int CYCLE_LIMIT = 500000;
	localparam int SETTLE      = 40;
	localparam int PHASE_WORDS = 95;
	localparam int PHASES      = 8;

	typedef struct {
		logic [CW-1:0] px;
		logic [CW-1:0] py;
		logic [CW-1:0] pz;
		logic          last;
	} forecast_t;

	// mirrors the history, smoothing and frame factor of the block
	class landmark_forecast;
		int unsigned horizon, max_step, blend, flim;
		logic [CW-1:0] prev_x [NPTS];
		logic [CW-1:0] prev_y [NPTS];
		logic [CW-1:0] smooth_x [NPTS];
		logic [CW-1:0] smooth_y [NPTS];
		bit has_history;
		int unsigned last_tick, slot, factor, slots_written, errors;
		forecast_t pending [$];

		function new();
			horizon = 32'(lesm_pkg::HORIZON_RST);
			max_step = 32'(lesm_pkg::MAX_STEP_RST);
			blend = 32'(lesm_pkg::BLEND_RST);
			flim = 32'(lesm_pkg::FACTOR_LIM_RST);
			has_history = 1'b0;
			last_tick = 0;
			slot = 0;
			factor = 0;
			slots_written = 0;
			errors = 0;
		endfunction

		function void set_reg(logic [lesm_pkg::CFG_ADDR_W-1:0] idx,
				logic [lesm_pkg::CFG_DATA_W-1:0] v);
			case (idx)
				lesm_pkg::REG_HORIZON: horizon = 32'(v[lesm_pkg::HORIZON_W-1:0]);
				lesm_pkg::REG_MAX_STEP: max_step = 32'(v);
				lesm_pkg::REG_BLEND: blend = 32'(v);
				lesm_pkg::REG_FACTOR_LIM: flim = 32'(v);
				default: ;
			endcase
		endfunction

		function logic [CW-1:0] advance(int unsigned cur, int unsigned prev,
				int unsigned sm);
			longint lim, diff, mag, motion, p, w, acc, f;
			lim = longint'(max_step);
			f = longint'(factor);
			diff = longint'(cur) - longint'(prev);
			if (diff > lim) diff = lim;
			if (diff < -lim) diff = -lim;
			mag = (diff < 0) ? -diff : diff;
			motion = (mag * f + 8192) >>> 14;
			if (diff < 0) motion = -motion;
			p = longint'(cur) + motion;
			if (p < 0) p = 0;
			if (p > 32768) p = 32768;
			w = (blend > 32768) ? 32768 : longint'(blend);
			acc = w * p + (32768 - w) * longint'(sm) + 16384;
			return CW'(acc >>> 15);
		endfunction

		function void note_word(logic op, logic [lesm_pkg::TICK_W-1:0] tick,
				logic [CW-1:0] px, logic [CW-1:0] py, logic [CW-1:0] pz, logic last);
			int unsigned x, y, i, dt, f;
			forecast_t r;
			if (op == lesm_pkg::OP_CLEAR) begin
				has_history = 1'b0;
				slot = 0;
				return;
			end
			x = (px > lesm_pkg::ONE_Q15) ? 32'(lesm_pkg::ONE_Q15) : 32'(px);
			y = (py > lesm_pkg::ONE_Q15) ? 32'(lesm_pkg::ONE_Q15) : 32'(py);
			i = (slot < NPTS) ? slot : 0;
			if (i == 0) begin
				if (has_history) begin
					dt = tick - last_tick;
					if (dt == 0) dt = 1;
					f = (horizon * 16384) / dt;
					factor = (f > flim) ? flim : f;
				end
				last_tick = tick;
			end
			if (has_history) begin
				r.px = advance(x, 32'(prev_x[i]), 32'(smooth_x[i]));
				r.py = advance(y, 32'(prev_y[i]), 32'(smooth_y[i]));
			end else begin
				r.px = CW'(x);
				r.py = CW'(y);
			end
			r.pz = pz;
			r.last = last;
			prev_x[i] = CW'(x);
			prev_y[i] = CW'(y);
			smooth_x[i] = r.px;
			smooth_y[i] = r.py;
			if (i + 1 > slots_written) slots_written = i + 1;
			if (last || i + 1 >= NPTS) begin
				slot = 0;
				has_history = 1'b1;
			end else begin
				slot = i + 1;
			end
			pending.push_back(r);
		endfunction

		function void check_word(logic [lesm_pkg::OUT_DATA_W-1:0] data, logic last);
			forecast_t e;
			if (pending.size() == 0) begin
				errors++;
				$display("%0t: unexpected word, expected none, actual data=%h last=%b",
					$time, data, last);
				return;
			end
			e = pending.pop_front();
			if (data[15:0] !== e.px) begin
				errors++;
				$display("%0t: pred_x expected %0d actual %0d", $time, e.px, data[15:0]);
			end
			if (data[31:16] !== e.py) begin
				errors++;
				$display("%0t: pred_y expected %0d actual %0d", $time, e.py, data[31:16]);
			end
			if (data[47:32] !== e.pz) begin
				errors++;
				$display("%0t: pred_z expected %0d actual %0d", $time,
					$signed(e.pz), $signed(data[47:32]));
			end
			if (last !== e.last) begin
				errors++;
				$display("%0t: last_point expected %b actual %b", $time, e.last, last);
			end
		endfunction
	endclass

	logic                                clk;
	logic                                arst_n;
	logic                                cfg_we;
	logic [lesm_pkg::CFG_ADDR_W-1:0]     cfg_addr;
	logic [lesm_pkg::CFG_DATA_W-1:0]     cfg_wdata;
	logic                                s_tvalid;
	logic                                s_tready;
	logic [lesm_pkg::IN_DATA_W-1:0]      s_tdata;
	logic                                s_tuser;
	logic                                s_tlast;
	logic                                m_tvalid;
	logic                                m_tready;
	logic [lesm_pkg::OUT_DATA_W-1:0]     m_tdata;
	logic                                m_tlast;

	landmark_forecast track = new();
	bit steady;
	int words_sent;
	int cycles;
	logic [lesm_pkg::TICK_W-1:0] frame_tick;
	int walk_x [NPTS];
	int walk_y [NPTS];

	landmark_extrapolate_smooth_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) begin
			track.note_word(s_tuser, s_tdata[31:0], s_tdata[47:32], s_tdata[63:48],
				s_tdata[79:64], s_tlast);
		end
		if (arst_n && m_tvalid && m_tready) begin
			track.check_word(m_tdata, m_tlast);
		end
	end

	// result side back-pressure, one draw per word
	initial begin
		int stall;
		m_tready = 1'b0;
		forever begin
			stall = steady ? 0 : $urandom_range(0, 10);
			if (stall > 0) begin
				@(negedge clk);
				m_tready <= 1'b0;
				repeat (stall - 1) @(negedge clk);
			end
			@(negedge clk);
			m_tready <= 1'b1;
			do @(posedge clk); while (!(m_tvalid && m_tready));
		end
	end

	function automatic logic [CW-1:0] pick_coord(inout int walk);
		int r;
		r = $urandom_range(0, 19);
		if (r == 0) return CW'($urandom_range(0, 65535));
		if (r == 1) walk = 0;
		else if (r == 2) walk = int'(lesm_pkg::ONE_Q15);
		else walk = walk + int'($urandom_range(0, 8000)) - 4000;
		if (walk < 0) walk = 0;
		if (walk > int'(lesm_pkg::ONE_Q15)) walk = int'(lesm_pkg::ONE_Q15);
		return CW'(walk);
	endfunction

	// all driving tasks start and end on a falling edge
	task automatic idle_in();
		int gap;
		gap = steady ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic push_word(logic op, logic [lesm_pkg::TICK_W-1:0] tick,
			logic [CW-1:0] px, logic [CW-1:0] py, logic [CW-1:0] pz, logic last);
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {pz, py, px, tick};
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
		words_sent++;
		@(negedge clk);
	endtask

	// never let a frame with history run past the slots already filled
	task automatic send_point(logic [lesm_pkg::TICK_W-1:0] tick, logic [CW-1:0] px,
			logic [CW-1:0] py, logic [CW-1:0] pz, logic last, output bit ended);
		logic fe;
		fe = last;
		if (track.has_history && track.slot + 1 >= track.slots_written) fe = 1'b1;
		ended = fe || (track.slot + 1 >= NPTS);
		idle_in();
		push_word(lesm_pkg::OP_POINT, tick, px, py, pz, fe);
	endtask

	task automatic send_clear();
		idle_in();
		push_word(lesm_pkg::OP_CLEAR, $urandom, CW'($urandom), CW'($urandom),
			CW'($urandom), 1'($urandom));
	endtask

	task automatic send_frame();
		int len;
		bit keep_last, ended;
		logic [lesm_pkg::TICK_W-1:0] tick;
		logic [CW-1:0] px, py;
		len = ($urandom_range(0, 3) == 0) ? NPTS : int'($urandom_range(1, NPTS));
		keep_last = ($urandom_range(0, 11) != 0);
		case ($urandom_range(0, 9))
			7: ;
			8: frame_tick += $urandom_range(1, 5);
			9: frame_tick = $urandom;
			default: frame_tick += $urandom_range(15, 80);
		endcase
		for (int k = 0; k < len; k++) begin
			// broken frame: history dropped part way through
			if ($urandom_range(0, 49) == 0) begin
				send_clear();
				return;
			end
			tick = (track.slot == 0) ? frame_tick : $urandom;
			px = pick_coord(walk_x[track.slot]);
			py = pick_coord(walk_y[track.slot]);
			send_point(tick, px, py, CW'($urandom), (k == len - 1) && keep_last, ended);
			if (ended) return;
		end
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (track.pending.size() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_reg(logic [lesm_pkg::CFG_ADDR_W-1:0] idx,
			logic [lesm_pkg::CFG_DATA_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= v;
		track.set_reg(idx, v);
		@(negedge clk);
	endtask

	task automatic set_regs(logic [15:0] h, logic [15:0] s, logic [15:0] b, logic [15:0] f);
		write_reg(lesm_pkg::REG_HORIZON, h);
		write_reg(lesm_pkg::REG_MAX_STEP, s);
		write_reg(lesm_pkg::REG_BLEND, b);
		write_reg(lesm_pkg::REG_FACTOR_LIM, f);
		cfg_we <= 1'b0;
	endtask

	initial begin
		logic [15:0] ph_h [PHASES];
		logic [15:0] ph_s [PHASES];
		logic [15:0] ph_b [PHASES];
		logic [15:0] ph_f [PHASES];
		bit done, paused;
		int start;
		ph_h = '{16'd45, 16'd0, 16'hFFFF, 16'd1000, 16'd1, 16'd1023, 16'd0, 16'd500};
		ph_s = '{16'd2621, 16'd0, 16'hFFFF, 16'd32768, 16'd1, 16'd32768, 16'd0, 16'd8000};
		ph_b = '{16'd24576, 16'd0, 16'hFFFF, 16'd32768, 16'd1, 16'd40000, 16'd0, 16'd16000};
		ph_f = '{16'd24576, 16'd0, 16'hFFFF, 16'd16384, 16'd1, 16'd0, 16'd0, 16'd40000};
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_addr = '0;
		cfg_wdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = lesm_pkg::OP_POINT;
		s_tlast = 1'b0;
		steady = 1'b0;
		words_sent = 0;
		cycles = 0;
		frame_tick = 32'd5000;
		foreach (walk_x[i]) begin
			walk_x[i] = 16384;
			walk_y[i] = 16384;
		end
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// first frame passes through, coordinates saturate
		send_point(32'd1000, 16'd0, 16'd32768, 16'h8000, 1'b0, done);
		send_point(32'd1000, 16'hFFFF, 16'd40000, 16'h7FFF, 1'b0, done);
		send_point(32'd1000, 16'd16384, 16'd1, 16'h0000, 1'b1, done);
		// same tick: interval of zero, factor limited
		send_point(32'd1000, 16'd2000, 16'd30000, 16'h0001, 1'b0, done);
		send_point(32'd1000, 16'hFFFF, 16'd0, 16'hFFFF, 1'b0, done);
		send_point(32'd1000, 16'd0, 16'd32768, 16'h0005, 1'b1, done);
		// tick steps back: huge interval, zero factor
		send_point(32'd999, 16'd100, 16'd200, 16'h0003, 1'b0, done);
		send_point(32'd999, 16'd32768, 16'd32768, 16'h0004, 1'b0, done);
		send_point(32'd999, 16'd5000, 16'd5000, 16'h0007, 1'b1, done);
		send_clear();
		send_point(32'hFFFF_FFF0, 16'd1000, 16'd1000, 16'h1234, 1'b0, done);
		send_point(32'hFFFF_FFF0, 16'd2000, 16'd2000, 16'hEDCB, 1'b1, done);
		// tick wraps through zero
		send_point(32'h0000_0010, 16'd1500, 16'd2600, 16'h0100, 1'b0, done);
		send_point(32'h0000_0010, 16'd1800, 16'd1900, 16'hFF00, 1'b1, done);
		send_point(32'd60, 16'd3000, 16'd3000, 16'h0000, 1'b0, done);
		send_clear();
		send_point(32'd100, 16'd7000, 16'd9000, 16'h4000, 1'b1, done);
		send_point(32'd140, 16'd7400, 16'd8000, 16'hC000, 1'b1, done);

		for (int p = 0; p < PHASES; p++) begin
			drain();
			if (p == 6) begin
				set_regs(16'($urandom_range(0, 1023)), 16'($urandom_range(0, 32768)),
					16'($urandom_range(0, 32768)), 16'($urandom_range(0, 65535)));
			end else begin
				set_regs(ph_h[p], ph_s[p], ph_b[p], ph_f[p]);
			end
			steady = (p == 2 || p == 5);
			start = words_sent;
			paused = 1'b0;
			while (words_sent - start < PHASE_WORDS) begin
				if (p == 3 && !paused && words_sent - start >= 40) begin
					drain();
					paused = 1'b1;
				end
				if ($urandom_range(0, 11) == 0) send_clear();
				else send_frame();
			end
		end

		drain();
		if (track.errors == 0 && track.pending.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/lesm_pkg.sv
hdl/lesm_div.sv
hdl/lesm_ctrl.sv
hdl/lesm_dp.sv
hdl/landmark_extrapolate_smooth_core.sv
test/tb.sv
